@@ rtl/kdt_pkg.sv @@
// ----------------------------------------------------------------------------
// kdt_pkg
// shared constants, command and status codes, and types of the keyed device
// table
// ----------------------------------------------------------------------------
`default_nettype none

package kdt_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int RESULT_LIMIT = 16;

  localparam int CMD_W  = 3;
  localparam int KEY_W  = 16;
  localparam int EP_W   = 8;
  localparam int EXT_W  = 64;
  localparam int MAXC_W = 5;
  localparam int STAT_W = 2;
  localparam int TOT_W  = 5;

  localparam int WORD_W = EP_W + EXT_W + 1;

  // wide enough for index and count arithmetic without overflow
  localparam int CW = CNT_W + 1;
  localparam int IW = (IDX_W + 1 > TOT_W) ? IDX_W + 1 : TOT_W;
  localparam int MW = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

  localparam int IN_DATA_W  = ((KEY_W + EP_W + EXT_W + MAXC_W + 7) / 8) * 8;
  localparam int IN_USER_W  = CMD_W;
  localparam int OUT_DATA_W = ((KEY_W + EP_W + EXT_W + 1 + TOT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STAT_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_SET_EXT  = 3'd1,
    CMD_BIND     = 3'd2,
    CMD_LOOKUP   = 3'd3,
    CMD_REMOVE   = 3'd4,
    CMD_CLEAR    = 3'd5,
    CMD_READ_ALL = 3'd6
  } kdt_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } kdt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RMW,
    S_SHIFT,
    S_DUMP,
    S_RESP
  } kdt_state_t;

  typedef struct packed {
    logic [EP_W-1:0]  endpoint;
    logic [EXT_W-1:0] extended;
    logic             bound;
  } kdt_word_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [KEY_W-1:0] wr_key;
    logic             shift_en;
    logic [IDX_W-1:0] shift_idx;
  } kdt_key_op_t;

  typedef struct packed {
    kdt_status_t      status;
    logic             evalid;
    logic [KEY_W-1:0] key;
    logic [EP_W-1:0]  endpoint;
    logic [EXT_W-1:0] extended;
    logic             bound;
    logic [TOT_W-1:0] total;
    logic             last;
  } kdt_result_t;

endpackage

`default_nettype wire

@@ rtl/kdt_ram.sv @@
// ----------------------------------------------------------------------------
// kdt_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kdt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/kdt_keys.sv @@
// ----------------------------------------------------------------------------
// kdt_keys
// key registers with parallel compare, lowest matching live slot wins;
// remove closes the gap by moving every later key down one slot
// ----------------------------------------------------------------------------
`default_nettype none

module kdt_keys (
  input  wire logic                       clk,
  input  wire kdt_pkg::kdt_key_op_t       op,
  input  wire logic [kdt_pkg::KEY_W-1:0]  search_key,
  input  wire logic [kdt_pkg::CNT_W-1:0]  used,
  input  wire logic [kdt_pkg::IDX_W-1:0]  rd_idx,
  output logic                            hit,
  output logic      [kdt_pkg::IDX_W-1:0]  hit_idx,
  output logic      [kdt_pkg::KEY_W-1:0]  rd_key
);
  import kdt_pkg::*;

  logic [KEY_W-1:0] key_r [MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_slot
    if (g < MAX_ENTRIES - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (op.shift_en && (IDX_W'(g) >= op.shift_idx)) begin
          key_r[g] <= key_r[g+1];
        end else if (op.wr_en && (op.wr_idx == IDX_W'(g))) begin
          key_r[g] <= op.wr_key;
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (op.wr_en && (op.wr_idx == IDX_W'(g))) begin
          key_r[g] <= op.wr_key;
        end
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if ((key_r[j] == search_key) && (CNT_W'(j) < used)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  assign rd_key = key_r[rd_idx];

endmodule

`default_nettype wire

@@ rtl/keyed_device_table_core.sv @@
// ----------------------------------------------------------------------------
// keyed_device_table_core
// associative device table keyed by a 16-bit short address, with ordered
// compaction on remove
// ----------------------------------------------------------------------------
// Keys sit in registers and are compared in parallel; endpoint, extended
// address and bound flag sit in a registered-read ram. One command is worked
// at a time. Add of a new key, lookup, clear, a miss and a full table pass
// through accept, execute and response; refreshing a present entry (add, set
// extended address, mark bound) adds a modify step, as the ram word is read,
// modified and written back. Remove adds one shift step per later entry moved
// down in the ram. Read all sends each beat from a dump step. A stalled result
// beat holds in the output register; the command after it is accepted
// meanwhile. No clearing pass is needed after reset.
`default_nettype none

module keyed_device_table_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // key_addr, endpoint_in, extended_in, max_count, zero pad
  input  wire logic [kdt_pkg::IN_DATA_W-1:0]   in_tdata,
  // command
  input  wire logic [kdt_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // entry_key, entry_endpoint, entry_extended, entry_bound, entry_total, zero pad
  output logic      [kdt_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status, entry_valid
  output logic      [kdt_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                                 out_tlast
);
  import kdt_pkg::*;

  kdt_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [TOT_W-1:0]  n_r, n_nxt;
  kdt_status_t       status_r, status_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  kdt_result_t       res_r, res_nxt;
  logic              out_load;

  kdt_cmd_t          cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [EP_W-1:0]   ep_r;
  logic [EXT_W-1:0]  ext_r;
  logic [MAXC_W-1:0] maxc_r;

  logic              in_beat;
  logic              out_free;

  kdt_key_op_t       key_op;
  logic              key_hit;
  logic [IDX_W-1:0]  key_hit_idx;
  logic [KEY_W-1:0]  key_rd;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  kdt_word_t         ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  kdt_word_t         rd_word;

  logic [CW-1:0]     used_ext;
  logic [CW-1:0]     hit_ext;
  logic [CW-1:0]     ptr_ext;
  logic [MW-1:0]     n_min;
  logic [IW-1:0]     ptr_inc;

  kdt_keys u_keys (
    .clk        (clk),
    .op         (key_op),
    .search_key (key_r),
    .used       (used_r),
    .rd_idx     (ptr_r),
    .hit        (key_hit),
    .hit_idx    (key_hit_idx),
    .rd_key     (key_rd)
  );

  kdt_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_word  = kdt_word_t'(ram_rdata);
  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign used_ext = CW'(used_r);
  assign hit_ext  = CW'(key_hit_idx);
  assign ptr_ext  = CW'(ptr_r);
  assign ptr_inc  = IW'(ptr_r) + IW'(1);

  always_comb begin
    n_min = (MW'(used_r) < MW'(maxc_r)) ? MW'(used_r) : MW'(maxc_r);
    if (n_min > MW'(RESULT_LIMIT)) begin
      n_min = MW'(RESULT_LIMIT);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    ptr_nxt    = ptr_r;
    n_nxt      = n_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    in_tready  = 1'b0;
    out_load   = 1'b0;
    res_nxt    = res_r;
    key_op     = '0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r;
    ram_wdata  = rd_word;
    ram_re     = 1'b0;
    ram_raddr  = key_hit_idx;

    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        hit_nxt    = 1'b0;
        status_nxt = STAT_OK;
        if (in_beat) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        ptr_nxt = key_hit_idx;
        unique case (cmd_r)
          CMD_ADD: begin
            if (key_hit) begin
              ram_re    = 1'b1;
              state_nxt = S_RMW;
            end else if (used_r >= CNT_W'(MAX_ENTRIES)) begin
              status_nxt = STAT_FULL;
              state_nxt  = S_RESP;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = used_r[IDX_W-1:0];
              ram_wdata.endpoint = ep_r;
              ram_wdata.extended = '0;
              ram_wdata.bound    = 1'b0;
              key_op.wr_en       = 1'b1;
              key_op.wr_idx      = used_r[IDX_W-1:0];
              key_op.wr_key      = key_r;
              used_nxt           = used_r + CNT_W'(1);
              state_nxt          = S_RESP;
            end
          end
          CMD_SET_EXT, CMD_BIND: begin
            if (key_hit) begin
              ram_re    = 1'b1;
              state_nxt = S_RMW;
            end else begin
              status_nxt = STAT_NOT_FOUND;
              state_nxt  = S_RESP;
            end
          end
          CMD_LOOKUP: begin
            if (key_hit) begin
              ram_re  = 1'b1;
              hit_nxt = 1'b1;
            end else begin
              status_nxt = STAT_NOT_FOUND;
            end
            state_nxt = S_RESP;
          end
          CMD_REMOVE: begin
            if (key_hit) begin
              key_op.shift_en  = 1'b1;
              key_op.shift_idx = key_hit_idx;
              if (hit_ext + CW'(1) < used_ext) begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(hit_ext + CW'(1));
                state_nxt = S_SHIFT;
              end else begin
                used_nxt  = used_r - CNT_W'(1);
                state_nxt = S_RESP;
              end
            end else begin
              status_nxt = STAT_NOT_FOUND;
              state_nxt  = S_RESP;
            end
          end
          CMD_CLEAR: begin
            used_nxt  = '0;
            state_nxt = S_RESP;
          end
          CMD_READ_ALL: begin
            n_nxt   = TOT_W'(n_min);
            ptr_nxt = '0;
            if (n_min == '0) begin
              state_nxt = S_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = S_DUMP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_RMW: begin
        ram_we = 1'b1;
        unique case (cmd_r)
          CMD_ADD:     ram_wdata.endpoint = ep_r;
          CMD_SET_EXT: ram_wdata.extended = ext_r;
          CMD_BIND:    ram_wdata.bound    = 1'b1;
          default:     ram_wdata          = rd_word;
        endcase
        state_nxt = S_RESP;
      end

      S_SHIFT: begin
        ram_we = 1'b1;
        if (ptr_ext + CW'(2) < used_ext) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(ptr_ext + CW'(2));
          ptr_nxt   = ptr_r + IDX_W'(1);
        end else begin
          used_nxt  = used_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_load         = 1'b1;
          res_nxt.status   = STAT_OK;
          res_nxt.evalid   = 1'b1;
          res_nxt.key      = key_rd;
          res_nxt.endpoint = rd_word.endpoint;
          res_nxt.extended = rd_word.extended;
          res_nxt.bound    = rd_word.bound;
          res_nxt.total    = n_r;
          res_nxt.last     = (ptr_inc == IW'(n_r));
          if (ptr_inc == IW'(n_r)) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(ptr_inc);
            ptr_nxt   = IDX_W'(ptr_inc);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load         = 1'b1;
          res_nxt.status   = status_r;
          res_nxt.evalid   = hit_r;
          res_nxt.key      = hit_r ? key_r : '0;
          res_nxt.endpoint = hit_r ? rd_word.endpoint : '0;
          res_nxt.extended = hit_r ? rd_word.extended : '0;
          res_nxt.bound    = hit_r ? rd_word.bound : 1'b0;
          res_nxt.total    = (cmd_r == CMD_READ_ALL) ? '0 : TOT_W'(used_r);
          res_nxt.last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    res_r    <= res_nxt;
    if (in_beat) begin
      cmd_r  <= kdt_cmd_t'(in_tuser[CMD_W-1:0]);
      key_r  <= in_tdata[KEY_W-1:0];
      ep_r   <= in_tdata[KEY_W +: EP_W];
      ext_r  <= in_tdata[KEY_W+EP_W +: EXT_W];
      maxc_r <= in_tdata[KEY_W+EP_W+EXT_W +: MAXC_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.last;
  assign out_tuser  = {res_r.evalid, res_r.status};
  assign out_tdata  = {(OUT_DATA_W - (KEY_W + EP_W + EXT_W + 1 + TOT_W))'(0),
                       res_r.total, res_r.bound, res_r.extended,
                       res_r.endpoint, res_r.key};

`ifndef SYNTHESIS
  a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_no_same_slot_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write hit the same slot");

  a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (IW'(ptr_r) < IW'(n_r)))
    else $error("read all index past emit count");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (ptr_ext + CW'(1) < used_ext))
    else $error("compaction beyond live entries");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(res_r))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ test/keyed_device_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_device_table_core_tb
// self-checking testbench of the keyed device table core
// ----------------------------------------------------------------------------
// A shadow copy of the table predicts the result beats of every accepted
// command. The beats are checked field by field against those predictions.
// The stimulus starts with directed commands that cover the field extremes,
// every command, misses, read all limits and the unused command code. Next
// the table is filled until an add reports full. Random traffic, mostly over
// a small pool of keys, follows. Both sides of the stream idle and stall at
// random at rates that change from phase to phase; the last phase has none.
`timescale 1ns / 1ps

module keyed_device_table_core_tb;
  import kdt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int IN_FIELDS_W = KEY_W + EP_W + EXT_W + MAXC_W;
  localparam int OFS_EP      = KEY_W;
  localparam int OFS_EXT     = OFS_EP + EP_W;
  localparam int OFS_BOUND   = OFS_EXT + EXT_W;
  localparam int OFS_TOT     = OFS_BOUND + 1;
  localparam int KEY_POOL    = 24;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic out_tlast;

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count = 0;
  int idle_cycles = 0;

  logic [KEY_W-1:0] shadow_key [MAX_ENTRIES];
  logic [EP_W-1:0]  shadow_ep [MAX_ENTRIES];
  logic [EXT_W-1:0] shadow_ext [MAX_ENTRIES];
  logic             shadow_bound [MAX_ENTRIES];
  int               shadow_count;

  logic [KEY_W-1:0] key_pool [KEY_POOL];
  kdt_result_t expected_beats [$];
  kdt_result_t want_beat;

  keyed_device_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int shadow_find(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic kdt_result_t make_beat(kdt_status_t st, int slot, int total, logic fin);
    kdt_result_t b;
    b = '0;
    b.status = st;
    b.total  = total[TOT_W-1:0];
    b.last   = fin;
    if (slot >= 0) begin
      b.evalid   = 1'b1;
      b.key      = shadow_key[slot];
      b.endpoint = shadow_ep[slot];
      b.extended = shadow_ext[slot];
      b.bound    = shadow_bound[slot];
    end
    return b;
  endfunction

  // updates the shadow table and queues the beats the command yields
  function automatic void predict_table_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [EP_W-1:0] ep, logic [EXT_W-1:0] ext,
                                            logic [MAXC_W-1:0] maxc);
    int slot;
    int n;
    kdt_status_t st;
    slot = shadow_find(key);
    st = STAT_OK;
    case (cmd)
      CMD_ADD: begin
        if (slot >= 0) begin
          shadow_ep[slot] = ep;
        end else if (shadow_count >= MAX_ENTRIES) begin
          st = STAT_FULL;
        end else begin
          shadow_key[shadow_count]   = key;
          shadow_ep[shadow_count]    = ep;
          shadow_ext[shadow_count]   = '0;
          shadow_bound[shadow_count] = 1'b0;
          shadow_count++;
        end
        expected_beats.push_back(make_beat(st, -1, shadow_count, 1'b1));
      end
      CMD_SET_EXT, CMD_BIND: begin
        if (slot < 0) begin
          st = STAT_NOT_FOUND;
        end else if (cmd == CMD_SET_EXT) begin
          shadow_ext[slot] = ext;
        end else begin
          shadow_bound[slot] = 1'b1;
        end
        expected_beats.push_back(make_beat(st, -1, shadow_count, 1'b1));
      end
      CMD_LOOKUP: begin
        st = (slot < 0) ? STAT_NOT_FOUND : STAT_OK;
        expected_beats.push_back(make_beat(st, slot, shadow_count, 1'b1));
      end
      CMD_REMOVE: begin
        if (slot < 0) begin
          st = STAT_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_key[i]   = shadow_key[i+1];
            shadow_ep[i]    = shadow_ep[i+1];
            shadow_ext[i]   = shadow_ext[i+1];
            shadow_bound[i] = shadow_bound[i+1];
          end
          shadow_count--;
        end
        expected_beats.push_back(make_beat(st, -1, shadow_count, 1'b1));
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        expected_beats.push_back(make_beat(STAT_OK, -1, 0, 1'b1));
      end
      CMD_READ_ALL: begin
        n = (shadow_count < int'(maxc)) ? shadow_count : int'(maxc);
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        if (n == 0) begin
          expected_beats.push_back(make_beat(STAT_OK, -1, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            expected_beats.push_back(make_beat(STAT_OK, i, n, i == n - 1));
          end
        end
      end
      default: begin
        expected_beats.push_back(make_beat(STAT_OK, -1, shadow_count, 1'b1));
      end
    endcase
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [EP_W-1:0] ep, input logic [EXT_W-1:0] ext,
                          input logic [MAXC_W-1:0] maxc);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, maxc, ext, ep, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_table_cmd(cmd, key, ep, ext, maxc);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 35) return CMD_ADD;
    if (r < 47) return CMD_SET_EXT;
    if (r < 57) return CMD_BIND;
    if (r < 72) return CMD_LOOKUP;
    if (r < 86) return CMD_REMOVE;
    if (r < 95) return CMD_READ_ALL;
    if (r < 98) return CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  task automatic test_directed_commands();
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd16);
    send_cmd(CMD_LOOKUP, 16'hFFFF, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_ADD, 16'h0000, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_ADD, 16'hFFFF, 8'hFF, 64'h0, 5'd0);
    send_cmd(CMD_ADD, 16'h1234, 8'h81, 64'h0, 5'd0);
    send_cmd(CMD_ADD, 16'h0000, 8'h5A, 64'h0, 5'd0);
    send_cmd(CMD_SET_EXT, 16'hFFFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_cmd(CMD_SET_EXT, 16'h0000, 8'h00, 64'hA5A5_0F0F_5A5A_F0F0, 5'd0);
    send_cmd(CMD_SET_EXT, 16'h4321, 8'h00, 64'h1, 5'd0);
    send_cmd(CMD_BIND, 16'h0000, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_BIND, 16'h4321, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_LOOKUP, 16'h0000, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_LOOKUP, 16'hFFFF, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd16);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd1);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd0);
    // remove from the head so later entries move down
    send_cmd(CMD_REMOVE, 16'h0000, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_LOOKUP, 16'h1234, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_REMOVE, 16'h0000, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_UNUSED, 16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd15);
    send_cmd(CMD_CLEAR, 16'h0000, 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd16);
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] key;
    while (shadow_count < MAX_ENTRIES) begin
      key = KEY_W'($urandom);
      if (shadow_find(key) < 0) send_cmd(CMD_ADD, key, 8'($urandom), 64'h0, 5'd0);
    end
    key = KEY_W'($urandom);
    while (shadow_find(key) >= 0) key = KEY_W'($urandom);
    send_cmd(CMD_ADD, key, 8'h3C, 64'h0, 5'd0);
    send_cmd(CMD_ADD, shadow_key[7], 8'hC3, 64'h0, 5'd0);
    send_cmd(CMD_SET_EXT, shadow_key[MAX_ENTRIES-1], 8'h00, {$urandom, $urandom}, 5'd0);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd16);
    // sender holds off until the table has answered everything
    wait_for_results();
    send_cmd(CMD_REMOVE, shadow_key[0], 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_REMOVE, shadow_key[shadow_count-1], 8'h00, 64'h0, 5'd0);
    send_cmd(CMD_READ_ALL, 16'h0000, 8'h00, 64'h0, 5'd16);
  endtask

  task automatic test_random_traffic(input int count);
    logic [KEY_W-1:0] key;
    logic [MAXC_W-1:0] maxc;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL-1)];
      else key = KEY_W'($urandom);
      maxc = $urandom_range(1) ? 5'd16 : MAXC_W'($urandom_range(16));
      send_cmd(pick_cmd(), key, 8'($urandom), {$urandom, $urandom}, maxc);
    end
  endtask

  function automatic void check_field(string name, logic [EXT_W-1:0] exp_v,
                                      logic [EXT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none actual tdata %h tuser %h tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("status", want_beat.status, out_tuser[STAT_W-1:0]);
        check_field("entry_valid", want_beat.evalid, out_tuser[STAT_W]);
        check_field("entry_key", want_beat.key, out_tdata[OFS_EP-1:0]);
        check_field("entry_endpoint", want_beat.endpoint, out_tdata[OFS_EXT-1:OFS_EP]);
        check_field("entry_extended", want_beat.extended, out_tdata[OFS_BOUND-1:OFS_EXT]);
        check_field("entry_bound", want_beat.bound, out_tdata[OFS_BOUND]);
        check_field("entry_total", want_beat.total, out_tdata[OFS_TOT+TOT_W-1:OFS_TOT]);
        check_field("last", want_beat.last, out_tlast);
      end
    end
  end

  // ends the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t timeout with %0d beats outstanding", $time, expected_beats.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    shadow_count = 0;
    sender_idle_pct = 27;
    receiver_stall_pct = 62;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_commands();
    test_table_full();
    test_random_traffic(22);
    sender_idle_pct = 62;
    receiver_stall_pct = 27;
    test_random_traffic(24);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random_traffic(18);

    wait_for_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kdt_pkg.sv
rtl/kdt_ram.sv
rtl/kdt_keys.sv
rtl/keyed_device_table_core.sv
test/keyed_device_table_core_tb.sv
